// ===== sv/sliding_window_lz_decoder_core_assert.svh =====
// Assertion macros shared by the sliding-window LZ decoder RTL.
// Clocked on the rising edge and disabled while the active-low reset is low.
`ifndef SLIDING_WINDOW_LZ_DECODER_CORE_ASSERT_SVH
`define SLIDING_WINDOW_LZ_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SWLZ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWLZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/swlz_pkg.sv =====
// Package for the sliding-window LZ decoder: window size, pointer and byte types,
// decoder state encoding and the ring access bundle. No dependencies.
package swlz_pkg;

    localparam int WIN_SLOTS = 255;
    localparam int PTR_W     = $clog2(WIN_SLOTS);
    localparam logic [7:0] ESCAPE_RESET = 8'hB4;

    typedef logic [7:0]       byte_t;
    typedef logic [PTR_W-1:0] ptr_t;

    localparam ptr_t SLOT_LAST = ptr_t'(WIN_SLOTS - 1);

    // Decoder state, one-hot
    typedef enum logic [3:0] {
        ST_NORMAL = 4'b0001,
        ST_ESCAPE = 4'b0010,
        ST_LENGTH = 4'b0100,
        ST_COPY   = 4'b1000
    } state_t;

    // Ring traffic in a cycle: a read, a write and an eviction clear
    typedef struct packed {
        logic  re;
        ptr_t  raddr;
        logic  we;
        ptr_t  waddr;
        byte_t wdata;
        logic  clr;
        ptr_t  caddr;
    } ring_ctl_t;

    function automatic ptr_t ptr_inc(input ptr_t a);
        ptr_t r;
        r = (a == SLOT_LAST) ? '0 : ptr_t'(a + ptr_t'(1));
        return r;
    endfunction

endpackage

// ===== sv/swlz_ring.sv =====
// History ring for the LZ decoder: synchronous memory with a registered read,
// per-slot valid flags for reset and eviction, and write-to-read forwarding. Uses swlz_pkg.
module swlz_ring (
    input  logic                clk,
    input  logic                rst_n,
    input  swlz_pkg::ring_ctl_t ctl,
    output swlz_pkg::byte_t     rd_data
);

    swlz_pkg::byte_t ring_mem [swlz_pkg::WIN_SLOTS];
    logic            slot_valid_reg [swlz_pkg::WIN_SLOTS];

    swlz_pkg::byte_t mem_q_reg;
    logic            vld_q_reg;
    logic            fwd_hit_reg;
    swlz_pkg::byte_t fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            ring_mem[ctl.waddr] <= ctl.wdata;
        end
        if (ctl.re)
        begin
            mem_q_reg    <= ring_mem[ctl.raddr];
            fwd_data_reg <= ctl.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < swlz_pkg::WIN_SLOTS; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
            vld_q_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                slot_valid_reg[ctl.caddr] <= 1'b0;
            end
            if (ctl.we)
            begin
                slot_valid_reg[ctl.waddr] <= 1'b1;
            end
            if (ctl.re)
            begin
                // a clear or write landing on the read slot this cycle overrides the array
                vld_q_reg   <= slot_valid_reg[ctl.raddr] &&
                               !(ctl.clr && (ctl.caddr == ctl.raddr));
                fwd_hit_reg <= ctl.we && (ctl.waddr == ctl.raddr);
            end
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : (vld_q_reg ? mem_q_reg : '0);

endmodule

// ===== sv/sliding_window_lz_decoder_core.sv =====
// Sliding-window LZ decoder: one compressed byte per input item, up to four decoded
// bytes per result item. The ring has a single read port with a registered read, so a
// copy, primed by the length byte, moves one byte per cycle unless a full output register
// holds a finished group; no input is taken until the copy ends. Results leave through
// an output register; the decoder stalls only when that register is full.
// Ring contents clear through per-slot valid flags, so there is no clearing pass after
// reset. Uses swlz_pkg, swlz_ring and sliding_window_lz_decoder_core_assert.svh.
`include "sliding_window_lz_decoder_core_assert.svh"

module sliding_window_lz_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic [7:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte0,
    output logic [7:0] out_byte1,
    output logic [7:0] out_byte2,
    output logic [7:0] out_byte3,
    output logic [2:0] byte_count,
    output logic       last_of_run
);

    swlz_pkg::state_t    state_reg, state_next;
    swlz_pkg::byte_t     esc_reg;
    swlz_pkg::ptr_t      wp_reg, wp_next;
    swlz_pkg::ptr_t      fill_reg, fill_next;
    swlz_pkg::byte_t     dist_reg, dist_next;
    swlz_pkg::byte_t     remain_reg, remain_next;
    swlz_pkg::ptr_t      src_reg, src_next;
    swlz_pkg::byte_t     pk_reg [3];
    swlz_pkg::byte_t     pk_next [3];
    logic [1:0]          pk_cnt_reg, pk_cnt_next;
    logic                out_valid_reg;
    swlz_pkg::byte_t     out_b_reg [4];
    logic [2:0]          out_cnt_reg;
    logic                out_last_reg;

    swlz_pkg::ring_ctl_t ring_ctl;
    swlz_pkg::byte_t     ring_rd;
    logic                accept;
    logic                out_free;
    logic                wr_en;
    swlz_pkg::byte_t     wr_byte;
    logic                push;
    logic                push_last;
    swlz_pkg::byte_t     push_b [4];
    logic                full;
    logic                last_byte;
    logic                group_done;
    swlz_pkg::ptr_t      dist_mod;
    swlz_pkg::ptr_t      src_calc;

    swlz_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ring_ctl),
        .rd_data (ring_rd)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg != swlz_pkg::ST_COPY) && out_free;
    assign accept   = in_valid && in_ready;
    assign full     = (fill_reg == swlz_pkg::SLOT_LAST);

    // distance modulo the window, then step back from the write pointer
    always_comb
    begin
        if (dist_reg >= swlz_pkg::byte_t'(swlz_pkg::WIN_SLOTS))
        begin
            dist_mod = swlz_pkg::ptr_t'(dist_reg - swlz_pkg::byte_t'(swlz_pkg::WIN_SLOTS));
        end
        else
        begin
            dist_mod = swlz_pkg::ptr_t'(dist_reg);
        end
        if (wp_reg >= dist_mod)
        begin
            src_calc = swlz_pkg::ptr_t'(wp_reg - dist_mod);
        end
        else
        begin
            src_calc = swlz_pkg::ptr_t'(wp_reg + (swlz_pkg::ptr_t'(swlz_pkg::WIN_SLOTS) - dist_mod));
        end
    end

    assign last_byte  = (remain_reg == swlz_pkg::byte_t'(1));
    assign group_done = (pk_cnt_reg == 2'd3) || last_byte;

    always_comb
    begin
        state_next  = state_reg;
        dist_next   = dist_reg;
        remain_next = remain_reg;
        src_next    = src_reg;
        pk_cnt_next = pk_cnt_reg;
        for (int j = 0; j < 3; j++)
        begin
            pk_next[j] = pk_reg[j];
        end
        wr_en          = 1'b0;
        wr_byte        = data_byte;
        push           = 1'b0;
        push_last      = 1'b1;
        ring_ctl       = '0;

        case (state_reg)
            swlz_pkg::ST_NORMAL:
            begin
                if (accept)
                begin
                    if (data_byte == esc_reg)
                    begin
                        state_next = swlz_pkg::ST_ESCAPE;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        push  = 1'b1;
                    end
                end
            end
            swlz_pkg::ST_ESCAPE:
            begin
                if (accept)
                begin
                    if (data_byte == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_byte    = esc_reg;
                        push       = 1'b1;
                        state_next = swlz_pkg::ST_NORMAL;
                    end
                    else
                    begin
                        dist_next  = data_byte;
                        state_next = swlz_pkg::ST_LENGTH;
                    end
                end
            end
            swlz_pkg::ST_LENGTH:
            begin
                if (accept)
                begin
                    if (data_byte == '0)
                    begin
                        state_next = swlz_pkg::ST_NORMAL;
                    end
                    else
                    begin
                        // prime the read pipeline with the first source slot
                        ring_ctl.re    = 1'b1;
                        ring_ctl.raddr = src_calc;
                        src_next       = swlz_pkg::ptr_inc(src_calc);
                        remain_next    = data_byte;
                        pk_cnt_next    = '0;
                        state_next     = swlz_pkg::ST_COPY;
                    end
                end
            end
            swlz_pkg::ST_COPY:
            begin
                // hold the fetched byte while a finished group cannot leave
                if (!(group_done && !out_free))
                begin
                    wr_en       = 1'b1;
                    wr_byte     = ring_rd;
                    remain_next = remain_reg - swlz_pkg::byte_t'(1);
                    if (!last_byte)
                    begin
                        ring_ctl.re    = 1'b1;
                        ring_ctl.raddr = src_reg;
                        src_next       = swlz_pkg::ptr_inc(src_reg);
                    end
                    else
                    begin
                        state_next = swlz_pkg::ST_NORMAL;
                    end
                    if (group_done)
                    begin
                        push        = 1'b1;
                        push_last   = last_byte;
                        pk_cnt_next = '0;
                    end
                    else
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            if (2'(j) == pk_cnt_reg)
                            begin
                                pk_next[j] = ring_rd;
                            end
                        end
                        pk_cnt_next = pk_cnt_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = swlz_pkg::ST_NORMAL;
            end
        endcase

        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (wr_en)
        begin
            ring_ctl.we    = 1'b1;
            ring_ctl.waddr = wp_reg;
            ring_ctl.wdata = wr_byte;
            ring_ctl.clr   = full;
            ring_ctl.caddr = swlz_pkg::ptr_inc(wp_reg);
            wp_next        = swlz_pkg::ptr_inc(wp_reg);
            if (!full)
            begin
                fill_next = fill_reg + swlz_pkg::ptr_t'(1);
            end
        end
    end

    // group packed bytes with the new byte; unused slots read as zero
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (2'(j) < pk_cnt_reg)
            begin
                push_b[j] = pk_reg[j];
            end
            else if (2'(j) == pk_cnt_reg)
            begin
                push_b[j] = wr_byte;
            end
            else
            begin
                push_b[j] = '0;
            end
        end
        push_b[3] = (pk_cnt_reg == 2'd3) ? wr_byte : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swlz_pkg::ST_NORMAL;
            esc_reg       <= swlz_pkg::ESCAPE_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            dist_reg      <= '0;
            remain_reg    <= '0;
            src_reg       <= '0;
            pk_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            dist_reg   <= dist_next;
            remain_reg <= remain_next;
            src_reg    <= src_next;
            pk_cnt_reg <= pk_cnt_next;
            if (cfg_write_en)
            begin
                esc_reg <= cfg_write_data;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            pk_reg[j] <= pk_next[j];
        end
        if (push)
        begin
            for (int j = 0; j < 4; j++)
            begin
                out_b_reg[j] <= push_b[j];
            end
            out_cnt_reg  <= 3'({1'b0, pk_cnt_reg}) + 3'd1;
            out_last_reg <= push_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte0   = out_b_reg[0];
    assign out_byte1   = out_b_reg[1];
    assign out_byte2   = out_b_reg[2];
    assign out_byte3   = out_b_reg[3];
    assign byte_count  = out_cnt_reg;
    assign last_of_run = out_last_reg;

    `SWLZ_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= swlz_pkg::SLOT_LAST,
        "fill count beyond window")
    `SWLZ_ASSERT_IMPLY(a_wp_bound, clk, rst_n, 1'b1, wp_reg <= swlz_pkg::SLOT_LAST,
        "write pointer beyond window")
    `SWLZ_ASSERT_IMPLY(a_copy_remain, clk, rst_n, state_reg == swlz_pkg::ST_COPY,
        remain_reg != '0, "copy running with nothing left")
    `SWLZ_ASSERT_IMPLY(a_count_range, clk, rst_n, out_valid_reg,
        out_cnt_reg >= 3'd1 && out_cnt_reg <= 3'd4, "result byte count out of range")
    `SWLZ_ASSERT_NEXT(a_copy_end, clk, rst_n,
        state_reg == swlz_pkg::ST_COPY && wr_en && last_byte,
        out_valid_reg && out_last_reg, "copy ended without a closing result")

endmodule

// ===== bench/sliding_window_lz_decoder_core_tb.sv =====
// Self-checking bench for sliding_window_lz_decoder_core: directed and random compressed
// streams under several escape codes, predicted by a scoreboard class and checked per item.
// Depends on swlz_pkg and the decoder RTL only.

typedef struct packed {
    swlz_pkg::byte_t b0;
    swlz_pkg::byte_t b1;
    swlz_pkg::byte_t b2;
    swlz_pkg::byte_t b3;
    logic [2:0]      count;
    logic            last;
} lz_result_t;

class lz_scoreboard;
    swlz_pkg::byte_t  ring [swlz_pkg::WIN_SLOTS];
    int unsigned      wr_pos;
    int unsigned      fill;
    swlz_pkg::state_t phase;
    swlz_pkg::byte_t  saved_dist;
    swlz_pkg::byte_t  escape;
    swlz_pkg::byte_t  run_bytes[$];
    lz_result_t       expected_q[$];
    int               errors;

    function new();
        foreach (ring[i])
            ring[i] = '0;
        wr_pos     = 0;
        fill       = 0;
        phase      = swlz_pkg::ST_NORMAL;
        saved_dist = '0;
        escape     = swlz_pkg::ESCAPE_RESET;
        errors     = 0;
    endfunction

    function void set_escape(swlz_pkg::byte_t v);
        escape = v;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Once the window is full, clear the oldest slot ahead of the write
    function void store_byte(swlz_pkg::byte_t b);
        if (fill >= swlz_pkg::WIN_SLOTS - 1)
            ring[(wr_pos + 1) % swlz_pkg::WIN_SLOTS] = '0;
        else
            fill++;
        ring[wr_pos] = b;
        wr_pos = (wr_pos + 1) % swlz_pkg::WIN_SLOTS;
        run_bytes.push_back(b);
    endfunction

    function void note_input(swlz_pkg::byte_t b);
        int unsigned src;
        int unsigned n;
        int unsigned base;
        lz_result_t  r;
        run_bytes.delete();
        case (phase)
            swlz_pkg::ST_ESCAPE:
            begin
                if (b == 8'd0)
                begin
                    store_byte(escape);
                    phase = swlz_pkg::ST_NORMAL;
                end
                else
                begin
                    saved_dist = b;
                    phase      = swlz_pkg::ST_LENGTH;
                end
            end
            swlz_pkg::ST_LENGTH:
            begin
                src = (wr_pos + swlz_pkg::WIN_SLOTS - (saved_dist % swlz_pkg::WIN_SLOTS))
                      % swlz_pkg::WIN_SLOTS;
                // read each source byte before its own write, so overlaps repeat
                for (int i = 0; i < b; i++)
                    store_byte(ring[(src + i) % swlz_pkg::WIN_SLOTS]);
                phase = swlz_pkg::ST_NORMAL;
            end
            default:
            begin
                if (b == escape)
                    phase = swlz_pkg::ST_ESCAPE;
                else
                    store_byte(b);
            end
        endcase
        base = 0;
        while (base < run_bytes.size())
        begin
            n = run_bytes.size() - base;
            if (n > 4)
                n = 4;
            r    = '0;
            r.b0 = run_bytes[base];
            if (n > 1)
                r.b1 = run_bytes[base + 1];
            if (n > 2)
                r.b2 = run_bytes[base + 2];
            if (n > 3)
                r.b3 = run_bytes[base + 3];
            r.count = n[2:0];
            base += 4;
            r.last = (base >= run_bytes.size());
            expected_q.push_back(r);
        end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got,
                                longint unsigned stamp);
        if (want != got)
        begin
            errors++;
            $display("%0d ns: %s mismatch, expected %0d, actual %0d",
                     stamp, name, want, got);
        end
    endfunction

    function void check_result(lz_result_t got, longint unsigned stamp);
        lz_result_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0d ns: unexpected result, expected none, actual %h", stamp, got);
            return;
        end
        want = expected_q.pop_front();
        compare_field("out_byte0", want.b0, got.b0, stamp);
        compare_field("out_byte1", want.b1, got.b1, stamp);
        compare_field("out_byte2", want.b2, got.b2, stamp);
        compare_field("out_byte3", want.b3, got.b3, stamp);
        compare_field("byte_count", want.count, got.count, stamp);
        compare_field("last_of_run", want.last, got.last, stamp);
    endfunction
endclass

module sliding_window_lz_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_write_en   = 1'b0;
    logic [7:0] cfg_write_data = 8'd0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte      = 8'd0;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [2:0] byte_count;
    logic       last_of_run;

    lz_scoreboard    sb;
    swlz_pkg::byte_t stream_q[$];
    bit              idle_on  = 1'b1;
    bit              hold_req = 1'b0;
    int              hold_left = 0;

    sliding_window_lz_decoder_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte0      (out_byte0),
        .out_byte1      (out_byte1),
        .out_byte2      (out_byte2),
        .out_byte3      (out_byte3),
        .byte_count     (byte_count),
        .last_of_run    (last_of_run)
    );

    always #4 clk = ~clk;

    // Note inputs before results so both see the same edge consistently
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(data_byte);
            if (out_valid && out_ready)
                sb.check_result({out_byte0, out_byte1, out_byte2, out_byte3,
                                 byte_count, last_of_run}, $time);
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = 400;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= !(idle_on && $urandom_range(0, 99) < 10);
        end
    end

    function automatic void push_literal(swlz_pkg::byte_t v, swlz_pkg::byte_t esc);
        stream_q.push_back(v);
        if (v == esc)
            stream_q.push_back(8'd0);
    endfunction

    function automatic void push_copy(swlz_pkg::byte_t back_dist, swlz_pkg::byte_t len,
                                      swlz_pkg::byte_t esc);
        stream_q.push_back(esc);
        stream_q.push_back(back_dist);
        stream_q.push_back(len);
    endfunction

    // Mostly well-formed literals and back-references, some raw noise
    function automatic void gen_random(int count, swlz_pkg::byte_t esc);
        int              pick;
        swlz_pkg::byte_t back_dist;
        swlz_pkg::byte_t len;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                push_literal(swlz_pkg::byte_t'($urandom_range(0, 255)), esc);
            else if (pick < 65)
            begin
                stream_q.push_back(esc);
                stream_q.push_back(8'd0);
            end
            else if (pick < 92)
            begin
                back_dist = ($urandom_range(0, 3) == 0)
                            ? swlz_pkg::byte_t'($urandom_range(1, 255))
                            : swlz_pkg::byte_t'($urandom_range(1, 16));
                len       = ($urandom_range(0, 29) == 0)
                            ? swlz_pkg::byte_t'($urandom_range(64, 255))
                            : swlz_pkg::byte_t'($urandom_range(0, 12));
                push_copy(back_dist, len, esc);
            end
            else
                stream_q.push_back(swlz_pkg::byte_t'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_stream();
        foreach (stream_q[i])
        begin
            if (idle_on && $urandom_range(0, 99) < 10)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            in_valid  <= 1'b1;
            data_byte <= stream_q[i];
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
        in_valid <= 1'b0;
        stream_q.delete();
    endtask

    // Let the last item be noted, then let silent items finish after the last result
    task automatic wait_drained();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_escape(swlz_pkg::byte_t v);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.set_escape(v);
    endtask

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        swlz_pkg::byte_t esc_list [4];
        swlz_pkg::byte_t esc;
        sb = new();
        esc_list[0] = 8'd0;
        esc_list[1] = 8'd255;
        esc_list[2] = swlz_pkg::byte_t'($urandom_range(1, 254));
        esc_list[3] = swlz_pkg::ESCAPE_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed stream under the reset escape code
        esc = swlz_pkg::ESCAPE_RESET;
        push_literal(8'h00, esc);
        push_literal(8'hFF, esc);
        push_literal(8'h55, esc);
        push_literal(8'hAA, esc);
        push_copy(8'd100, 8'd2, esc);   // distance beyond the bytes held
        stream_q.push_back(esc);        // escaped literal
        stream_q.push_back(8'd0);
        push_copy(8'd1, 8'd0, esc);     // zero length, silent
        push_copy(8'd1, 8'd255, esc);   // longest overlapping run, fills the window
        push_copy(8'd254, 8'd4, esc);   // oldest byte still held
        push_copy(8'd255, 8'd3, esc);   // wraps onto the cleared slot
        push_literal(8'h01, esc);
        send_stream();
        wait_drained();

        foreach (esc_list[p])
        begin
            esc = esc_list[p];
            write_escape(esc);
            idle_on = (p != 3);
            // previous phase left an escape pending: resolve it under the new code
            if (p == 2)
                stream_q.push_back(8'd0);
            gen_random(28, esc);
            if (p == 1)
                stream_q.push_back(esc);
            if (p == 2)
                hold_req = 1'b1;
            send_stream();
            wait_drained();
        end
        idle_on = 1'b1;

        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/swlz_pkg.sv
sv/swlz_ring.sv
sv/sliding_window_lz_decoder_core.sv
bench/sliding_window_lz_decoder_core_tb.sv
